### src/stac_pkg.sv
// Shared types and constants of the scaled tile alpha compositor.
// Used by the channel interfaces and by stac_addr, stac_blend and the top level.
`default_nettype none

package stac_pkg;

   localparam int SCALE_W = 4;
   localparam int IDX_W   = 12;
   localparam int COORD_W = 10;
   localparam int COLOR_W = 32;

   typedef enum logic {
      OP_LOAD      = 1'b0,
      OP_COMPOSITE = 1'b1
   } op_type;

   typedef struct packed {
      logic                 we;
      logic [COORD_W-1:0]   out_x;
      logic [COORD_W-1:0]   out_y;
      logic [COLOR_W-1:0]   dst;
   } stage1_type;

endpackage

`default_nettype wire

### src/stac_if.sv
// Valid/ready channel interfaces for the pixel request and result beats.
// Depends on stac_pkg for the field widths.
`default_nettype none

interface stac_req_if
   import stac_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic                operation;
   logic [9:0]          texel_index;
   logic [COLOR_W-1:0]  pixel_color;
   logic [2:0]          tile_pixel_x;
   logic [2:0]          tile_pixel_y;
   logic [1:0]          sub_x;
   logic [1:0]          sub_y;
   logic signed [8:0]   tile_screen_x;
   logic signed [8:0]   tile_screen_y;
   logic [1:0]          mirror;
   logic [63:0]         pixel_mask;

   modport source (
      output valid, operation, texel_index, pixel_color, tile_pixel_x, tile_pixel_y,
             sub_x, sub_y, tile_screen_x, tile_screen_y, mirror, pixel_mask,
      input  ready
   );
   modport sink (
      input  valid, operation, texel_index, pixel_color, tile_pixel_x, tile_pixel_y,
             sub_x, sub_y, tile_screen_x, tile_screen_y, mirror, pixel_mask,
      output ready
   );
endinterface

interface stac_rsp_if
   import stac_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic                write_enable;
   logic [COORD_W-1:0]  out_x;
   logic [COORD_W-1:0]  out_y;
   logic [COLOR_W-1:0]  color;

   modport source (
      output valid, write_enable, out_x, out_y, color,
      input  ready
   );
   modport sink (
      input  valid, write_enable, out_x, out_y, color,
      output ready
   );
endinterface

`default_nettype wire

### src/stac_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Stand-alone; no package needed.
`default_nettype none

module stac_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### src/stac_addr.sv
// Front stage: visibility and screen clipping, mirrored texel address and
// scaled coordinates, texel RAM access. Depends on stac_pkg and stac_req_if.
`default_nettype none

module stac_addr
   import stac_pkg::*;
#(
   parameter int MAX_SCALE     = 4,
   parameter int SCREEN_WIDTH  = 256,
   parameter int SCREEN_HEIGHT = 240,
   parameter int ADDR_W        = 10
) (
   input  wire logic                clock,
   input  wire logic                reset,
   stac_req_if.sink                 req_if,
   input  wire logic [SCALE_W-1:0]  scale,
   input  wire logic [6:0]          scale_sq,
   input  wire logic                stage_take,
   output logic                     ram_en,
   output logic                     ram_we,
   output logic [ADDR_W-1:0]        ram_addr,
   output logic [COLOR_W-1:0]       ram_wdata,
   output logic                     st1_valid,
   output stage1_type               st1
);

   localparam int Depth = 64 * MAX_SCALE * MAX_SCALE;

   logic               st1_valid_ff, st1_valid_in;
   stage1_type         st1_ff, st1_in;
   logic               accept, is_comp, sub_ok, vis, on_x, on_y, we;
   logic signed [11:0] sx, sy;
   logic [2:0]         tx_m, ty_m;
   logic [SCALE_W-1:0] subx_m, suby_m;
   logic [IDX_W-1:0]   idx, ti;
   logic [13:0]        ox, oy;

   always_comb begin
      req_if.ready = !st1_valid_ff || stage_take;
      accept  = req_if.valid && req_if.ready;
      is_comp = (req_if.operation == OP_COMPOSITE);
      sub_ok  = ({2'b00, req_if.sub_x} < scale) && ({2'b00, req_if.sub_y} < scale);
      vis     = req_if.pixel_mask[{req_if.tile_pixel_y, req_if.tile_pixel_x}];
      sx      = 12'(req_if.tile_screen_x) + $signed({9'b0, req_if.tile_pixel_x});
      sy      = 12'(req_if.tile_screen_y) + $signed({9'b0, req_if.tile_pixel_y});
      on_x    = !sx[11] && (sx < $signed(12'(SCREEN_WIDTH)));
      on_y    = !sy[11] && (sy < $signed(12'(SCREEN_HEIGHT)));
      we      = is_comp && sub_ok && vis && on_x && on_y;

      tx_m   = req_if.mirror[0] ? ~req_if.tile_pixel_x : req_if.tile_pixel_x;
      ty_m   = req_if.mirror[1] ? ~req_if.tile_pixel_y : req_if.tile_pixel_y;
      subx_m = req_if.mirror[0] ? SCALE_W'(scale - 1'b1 - {2'b00, req_if.sub_x})
                                : {2'b00, req_if.sub_x};
      suby_m = req_if.mirror[1] ? SCALE_W'(scale - 1'b1 - {2'b00, req_if.sub_y})
                                : {2'b00, req_if.sub_y};
      idx = IDX_W'(ty_m) * IDX_W'({scale_sq, 3'b000})
          + IDX_W'(suby_m) * IDX_W'({scale, 3'b000})
          + IDX_W'(tx_m) * IDX_W'(scale)
          + IDX_W'(subx_m);
      ti  = IDX_W'(req_if.texel_index);

      ox = 14'(sx[9:0]) * 14'(scale) + 14'(req_if.sub_x);
      oy = 14'(sy[9:0]) * 14'(scale) + 14'(req_if.sub_y);

      ram_we    = accept && !is_comp && (32'(ti) < 32'(Depth));
      ram_en    = ram_we || (accept && we);
      ram_addr  = is_comp ? idx[ADDR_W-1:0] : ti[ADDR_W-1:0];
      ram_wdata = req_if.pixel_color;

      st1_in.we    = we;
      st1_in.out_x = we ? ox[COORD_W-1:0] : '0;
      st1_in.out_y = we ? oy[COORD_W-1:0] : '0;
      st1_in.dst   = req_if.pixel_color;
      st1_valid_in = req_if.ready ? accept : st1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
      end else begin
         st1_valid_ff <= st1_valid_in;
      end
      if (accept) begin
         st1_ff <= st1_in;
      end
   end

   assign st1_valid = st1_valid_ff;
   assign st1       = st1_ff;

   a_load_no_write: assert property (@(posedge clock) disable iff (reset)
      accept && !is_comp |=> st1_valid_ff && !st1_ff.we)
      else $error("load beat produced a framebuffer write");

   a_ram_from_beat: assert property (@(posedge clock) disable iff (reset)
      ram_en |-> accept && (ram_we == !is_comp))
      else $error("texel RAM accessed without a matching beat");

   a_stage1_hold: assert property (@(posedge clock) disable iff (reset)
      st1_valid_ff && !stage_take |=> st1_valid_ff && $stable(st1_ff))
      else $error("stalled front stage lost its contents");

endmodule

`default_nettype wire

### src/stac_blend.sv
// Back stages: per-channel alpha products, divide by 255 and the result
// register. Depends on stac_pkg and stac_rsp_if.
`default_nettype none

module stac_blend
   import stac_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                st1_valid,
   input  wire stage1_type          st1,
   input  wire logic [COLOR_W-1:0]  texel,
   output logic                     stage_take,
   stac_rsp_if.source               rsp_if
);

   typedef struct packed {
      logic                 we;
      logic [COORD_W-1:0]   out_x;
      logic [COORD_W-1:0]   out_y;
      logic [COLOR_W-1:0]   dst;
      logic [COLOR_W-1:0]   src;
      logic [2:0][15:0]     sum;
   } stage2_type;

   logic               st2_valid_ff, st2_valid_in;
   stage2_type         st2_ff, st2_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               write_enable_ff;
   logic [COORD_W-1:0] out_x_ff;
   logic [COORD_W-1:0] out_y_ff;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic               take3, take2;
   logic [7:0]         alpha, alpha2;
   logic [2:0][7:0]    quot;
   logic [16:0]        acc;

   always_comb begin
      take3 = !rsp_valid_ff || rsp_if.ready;
      take2 = !st2_valid_ff || take3;
      stage_take = take2;

      alpha = texel[31:24];
      st2_in.we    = st1.we;
      st2_in.out_x = st1.out_x;
      st2_in.out_y = st1.out_y;
      st2_in.dst   = st1.dst;
      st2_in.src   = texel;
      for (int c = 0; c < 3; c++) begin
         st2_in.sum[c] = 16'(texel[c*8 +: 8]) * 16'(alpha)
                       + 16'(st1.dst[c*8 +: 8]) * 16'(8'hff - alpha)
                       + 16'h007f;
      end
      st2_valid_in = take2 ? st1_valid : st2_valid_ff;

      alpha2 = st2_ff.src[31:24];
      acc    = '0;
      for (int c = 0; c < 3; c++) begin
         acc     = 17'(st2_ff.sum[c]) + 17'(st2_ff.sum[c][15:8]) + 17'd1;
         quot[c] = acc[15:8];
      end
      priority if (!st2_ff.we) begin
         color_in = '0;
      end else if (alpha2 == 8'h00) begin
         color_in = st2_ff.dst;
      end else if (alpha2 == 8'hff) begin
         color_in = st2_ff.src;
      end else begin
         color_in = {8'hff, quot[2], quot[1], quot[0]};
      end
      rsp_valid_in = take3 ? st2_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st2_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st2_valid_ff <= st2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take2 && st1_valid) begin
         st2_ff <= st2_in;
      end
      if (take3 && st2_valid_ff) begin
         write_enable_ff <= st2_ff.we;
         out_x_ff        <= st2_ff.out_x;
         out_y_ff        <= st2_ff.out_y;
         color_ff        <= color_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.write_enable = write_enable_ff;
   assign rsp_if.out_x        = out_x_ff;
   assign rsp_if.out_y        = out_y_ff;
   assign rsp_if.color        = color_ff;

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !write_enable_ff |-> color_ff == '0 && out_x_ff == '0
                                           && out_y_ff == '0)
      else $error("result without write carries nonzero fields");

   a_stage2_hold: assert property (@(posedge clock) disable iff (reset)
      st2_valid_ff && !take3 |=> st2_valid_ff && $stable(st2_ff))
      else $error("stalled blend stage lost its contents");

   a_stage2_moves: assert property (@(posedge clock) disable iff (reset)
      st2_valid_ff && take3 |=> rsp_valid_ff)
      else $error("blend stage advanced without producing a result");

endmodule

`default_nettype wire

### src/scaled_tile_alpha_compositor_core.sv
// Top level of the scaled tile alpha compositor. Depends on stac_pkg, the
// channel interfaces, stac_ram, stac_addr and stac_blend.
//
// The block takes one beat per clock, loads and composites alike, when the
// result side does not stall, and gives one result beat for every request
// beat, which passes through the front stage, the product stage and the
// result register in turn. The rate is set by the single-port texel RAM,
// which serves one load write or one texel read each cycle; the front stage,
// the product stage and the result register each hold one beat. The texel RAM
// has 64*MAX_SCALE*MAX_SCALE words and is not cleared at reset, so every texel
// must be loaded before a composite beat reads it. The user must write the
// scale register through the csr port only while the block is idle; the block
// does not enforce this. Zero acts as one, values above MAX_SCALE as MAX_SCALE.
`default_nettype none

module scaled_tile_alpha_compositor_core
   import stac_pkg::*;
#(
   parameter int MAX_SCALE     = 4,
   parameter int SCREEN_WIDTH  = 256,
   parameter int SCREEN_HEIGHT = 240
) (
   input  wire logic        clock,
   input  wire logic        reset,
   stac_req_if.sink         req_if,
   stac_rsp_if.source       rsp_if,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_scale
);

   localparam int Depth = 64 * MAX_SCALE * MAX_SCALE;
   localparam int AddrW = $clog2(Depth);

   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [6:0]         scale_sq_ff, scale_sq_in;
   logic               ram_en, ram_we, st1_valid, stage_take;
   logic [AddrW-1:0]   ram_addr;
   logic [COLOR_W-1:0] ram_wdata, ram_rdata;
   stage1_type         st1;

   always_comb begin
      csr_ready = 1'b1;
      priority if (csr_scale == 3'd0) begin
         scale_in = SCALE_W'(1);
      end else if ({1'b0, csr_scale} > SCALE_W'(MAX_SCALE)) begin
         scale_in = SCALE_W'(MAX_SCALE);
      end else begin
         scale_in = {1'b0, csr_scale};
      end
      scale_sq_in = 7'(scale_in) * 7'(scale_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff    <= SCALE_W'(1);
         scale_sq_ff <= 7'd1;
      end else if (csr_valid && csr_ready) begin
         scale_ff    <= scale_in;
         scale_sq_ff <= scale_sq_in;
      end
   end

   stac_addr #(
      .MAX_SCALE     (MAX_SCALE),
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .ADDR_W        (AddrW)
   ) u_addr (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .scale      (scale_ff),
      .scale_sq   (scale_sq_ff),
      .stage_take (stage_take),
      .ram_en     (ram_en),
      .ram_we     (ram_we),
      .ram_addr   (ram_addr),
      .ram_wdata  (ram_wdata),
      .st1_valid  (st1_valid),
      .st1        (st1)
   );

   stac_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (Depth)
   ) u_texel_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   stac_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .st1_valid  (st1_valid),
      .st1        (st1),
      .texel      (ram_rdata),
      .stage_take (stage_take),
      .rsp_if     (rsp_if)
   );

endmodule

`default_nettype wire
